// ===== hw/rtl/column_post_clip_writer_unit_macros.svh =====
// ----------------------------------------------------------------------------
// column post clip writer assertion macros
// Concurrent assertion helpers used by the column post clip writer top module.
// ----------------------------------------------------------------------------
`ifndef COLUMN_POST_CLIP_WRITER_UNIT_MACROS_SVH
`define COLUMN_POST_CLIP_WRITER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// property that must hold on every edge outside reset
`define CPCW_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("cpcw assertion failed");

// antecedent implies consequent on the following edge
`define CPCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cpcw assertion failed");

`else

`define CPCW_ASSERT(lbl, clk, rst_n, prop)
`define CPCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/cpcw_pkg.sv =====
// ----------------------------------------------------------------------------
// cpcw_pkg
// Shared types and constants of the column post clip writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cpcw_pkg;

	// byte that ends a column when it stands in the top offset slot
	localparam logic [7:0] END_MARK = 8'hFF;

	// default depth of the queue between parser and writer
	localparam int QDEPTH = 2;

	// configuration register indexes
	typedef enum logic {
		CFG_ORIGIN_Y     = 1'b0,
		CFG_CACHE_HEIGHT = 1'b1
	} cfg_idx_t;

	// one queued result: a pixel write or a column end marker
	typedef struct packed {
		logic        col_end;
		logic [14:0] start_pos;
		logic [7:0]  data_idx;
		logic [7:0]  data;
	} entry_t;

	// queue status seen by the input handshake and the writer
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ===== hw/rtl/cpcw_front.sv =====
// ----------------------------------------------------------------------------
// cpcw_front
// Post parser: walks the post byte layout, works out the clip window of each
// post and emits write and column end entries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpcw_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [7:0]           column_byte,
	input  logic signed [15:0]   origin_y,
	input  logic [14:0]          cache_height,
	output logic                 push,
	output cpcw_pkg::entry_t     push_entry
);
	import cpcw_pkg::*;

	typedef enum logic [4:0] {
		PH_TOP  = 5'b00001,
		PH_LEN  = 5'b00010,
		PH_PAD1 = 5'b00100,
		PH_DATA = 5'b01000,
		PH_PAD2 = 5'b10000
	} phase_t;

	phase_t             phase_q;
	logic [7:0]         top_q;
	logic [7:0]         left_q;
	logic [7:0]         idx_q;
	logic               calc_pend_q;

	// post start and length captured with the length byte
	logic signed [16:0] pos_s1;
	logic [7:0]         len_s1;
	logic [14:0]        height_s1;

	// clip window of the current post
	logic [14:0]        start_s2;
	logic signed [16:0] cnt1_s2;
	logic signed [16:0] room_s2;

	logic signed [16:0] pos_next;
	logic               pos_neg;
	logic signed [16:0] len_ext;
	logic signed [16:0] height_ext;
	logic signed [16:0] idx_ext;
	logic               hit;

	assign pos_next   = {origin_y[15], origin_y} + {9'd0, top_q};
	assign pos_neg    = pos_s1[16];
	assign len_ext    = {9'd0, len_s1};
	assign height_ext = {2'd0, height_s1};
	assign idx_ext    = {9'd0, idx_q};

	// data byte lands inside the window when below both the count and the room
	assign hit = (idx_ext < cnt1_s2) && (idx_ext < room_s2);

	// phase sequencing and post counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_TOP;
			left_q      <= 8'd0;
			idx_q       <= 8'd0;
			calc_pend_q <= 1'b0;
		end else begin
			calc_pend_q <= 1'b0;
			if (accept) begin
				unique case (phase_q)
					PH_TOP: begin
						if (column_byte != END_MARK) begin
							phase_q <= PH_LEN;
						end
					end
					PH_LEN: begin
						left_q      <= column_byte;
						idx_q       <= 8'd0;
						calc_pend_q <= 1'b1;
						phase_q     <= PH_PAD1;
					end
					PH_PAD1: begin
						phase_q <= (left_q == 8'd0) ? PH_PAD2 : PH_DATA;
					end
					PH_DATA: begin
						idx_q  <= idx_q + 8'd1;
						left_q <= left_q - 8'd1;
						if (left_q == 8'd1) begin
							phase_q <= PH_PAD2;
						end
					end
					PH_PAD2: begin
						phase_q <= PH_TOP;
					end
					default: begin
						phase_q <= PH_TOP;
					end
				endcase
			end
		end
	end

	// top offset and post geometry capture
	always_ff @(posedge clk) begin
		if (accept && (phase_q == PH_TOP)) begin
			top_q <= column_byte;
		end
		if (accept && (phase_q == PH_LEN)) begin
			pos_s1    <= pos_next;
			len_s1    <= column_byte;
			height_s1 <= cache_height;
		end
	end

	// clip window, settled before the first data byte can arrive
	always_ff @(posedge clk) begin
		if (calc_pend_q) begin
			start_s2 <= pos_neg ? 15'd0 : pos_s1[14:0];
			cnt1_s2  <= pos_neg ? (pos_s1 + len_ext) : len_ext;
			room_s2  <= pos_neg ? height_ext : (height_ext - pos_s1);
		end
	end

	// entries toward the writer
	always_comb begin
		push       = 1'b0;
		push_entry = '0;
		if (accept && (phase_q == PH_TOP) && (column_byte == END_MARK)) begin
			push               = 1'b1;
			push_entry.col_end = 1'b1;
		end else if (accept && (phase_q == PH_DATA) && hit) begin
			push                 = 1'b1;
			push_entry.start_pos = start_s2;
			push_entry.data_idx  = idx_q;
			push_entry.data      = column_byte;
		end
	end

endmodule

// ===== hw/rtl/cpcw_queue.sv =====
// ----------------------------------------------------------------------------
// cpcw_queue
// Small first-in first-out queue of result entries between parser and writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpcw_queue #(
	parameter int DEPTH = cpcw_pkg::QDEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  cpcw_pkg::entry_t     push_entry,
	input  logic                 pop,
	output cpcw_pkg::entry_t     head,
	output cpcw_pkg::q_stat_t    stat
);
	import cpcw_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t          slots_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;

	assign stat.full  = (cnt_q == CW'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign head       = slots_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/cpcw_back.sv =====
// ----------------------------------------------------------------------------
// cpcw_back
// Writer: takes entries from the queue, forms the target row and holds the
// result in the output register until the receiver takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpcw_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cpcw_pkg::entry_t     head,
	input  cpcw_pkg::q_stat_t    stat,
	output logic                 pop,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [23:0]          m_tdata,   // [14:0] write_pos, [22:15] write_byte, [23] zero
	output logic                 m_tuser    // [0] column_end
);
	import cpcw_pkg::*;

	logic        valid_q;
	logic [14:0] pos_q;
	logic [7:0]  byte_q;
	logic        end_q;

	// refill the output register when it is empty or being taken
	assign pop = !stat.empty && (!valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	// row position is post start plus data index
	always_ff @(posedge clk) begin
		if (pop) begin
			pos_q  <= head.start_pos + {7'd0, head.data_idx};
			byte_q <= head.data;
			end_q  <= head.col_end;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {1'b0, byte_q, pos_q};
	assign m_tuser  = end_q;

endmodule

// ===== hw/rtl/column_post_clip_writer_unit.sv =====
// ----------------------------------------------------------------------------
// column_post_clip_writer_unit
// Sparse picture column decoder with vertical clipping of the pixel writes.
// ----------------------------------------------------------------------------
// Usage:
//   s_* stream carries one raw column byte per transaction (tdata[7:0]).
//   m_* stream carries results: a pixel write (row position, byte) or a
//   column end marker flagged in tuser with position and byte zero.
//   cfg_* writes origin_y (index 0, 16 bits signed) and cache_height
//   (index 1, low 15 bits); cfg_ready is always high. Write configuration
//   between posts or while the block is idle.
//   Throughput: one byte per cycle while s_tready is high; the parser takes
//   every accepted byte and the writer drains one result per cycle while
//   m_tready is high. Results pass the queue, then the output register;
//   bytes that make no result leave nothing on m_*.
//   Stall: results collect in a small queue and the output register; once
//   the queue is full s_tready drops until the receiver takes a result.
//   Reset: parser waits for a top offset, queue and output are empty,
//   origin_y is 0 and cache_height is 128.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "column_post_clip_writer_unit_macros.svh"

module column_post_clip_writer_unit #(
	parameter int QUEUE_DEPTH = cpcw_pkg::QDEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] column_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,    // [14:0] write_pos, [22:15] write_byte, [23] zero
	output logic        m_tuser,    // [0] column_end
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	import cpcw_pkg::*;

	logic signed [15:0] origin_y_q;
	logic [14:0]        cache_height_q;
	logic               accept;
	logic               push;
	entry_t             push_entry;
	entry_t             head;
	q_stat_t            q_stat;
	logic               pop;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_y_q     <= 16'sd0;
			cache_height_q <= 15'd128;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ORIGIN_Y:     origin_y_q     <= cfg_data;
				CFG_CACHE_HEIGHT: cache_height_q <= cfg_data[14:0];
				default:          origin_y_q     <= origin_y_q;
			endcase
		end
	end

	// input transaction
	assign s_tready = !q_stat.full;
	assign accept   = s_tvalid && s_tready;

	cpcw_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.column_byte  (s_tdata),
		.origin_y     (origin_y_q),
		.cache_height (cache_height_q),
		.push         (push),
		.push_entry   (push_entry)
	);

	cpcw_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.stat       (q_stat)
	);

	cpcw_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.stat     (q_stat),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// a column end result carries no write
	`CPCW_ASSERT(a_end_no_write, clk, arst_n, (m_tvalid && m_tuser) |-> (m_tdata == 24'd0))

	// output only turns valid when an entry was drained from the queue
	`CPCW_ASSERT(a_valid_from_pop, clk, arst_n, $rose(m_tvalid) |-> $past(pop))

	// a full queue with nothing drained cannot take another entry
	`CPCW_ASSERT_NEXT(a_full_holds, clk, arst_n, (q_stat.full && !pop), (!push || pop))

endmodule

// ===== bench/column_post_clip_writer_unit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// column post clip writer checker
// Watches the column byte, result and configuration channels and keeps its
// own copy of the post parser and clip window. It queues the pixel writes and
// column ends that each accepted byte must cause, then matches every result
// transaction against the oldest queued one.
// ----------------------------------------------------------------------------

module column_post_clip_writer_unit_checker
	import cpcw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] column_byte
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,    // [14:0] write_pos, [22:15] write_byte, [23] zero
	input  logic        m_tuser,    // [0] column_end
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          pending
);

	// where the parser stands within a post
	typedef enum logic [2:0] {
		AWAIT_TOP,
		AWAIT_LEN,
		SKIP_PAD_HEAD,
		TAKE_DATA,
		SKIP_PAD_TAIL
	} post_phase_t;

	// one pixel write or column end
	typedef struct packed {
		logic        fin;
		logic [14:0] row;
		logic [7:0]  pix;
	} pixel_write_t;

	post_phase_t        phase;
	logic signed [15:0] origin;
	logic [14:0]        height;
	logic [7:0]         top_ofs;
	logic [7:0]         bytes_rem;
	logic [7:0]         data_pos;
	logic [15:0]        first_row;
	logic [15:0]        row_count;
	pixel_write_t       expected_writes[$];
	pixel_write_t       seen;
	pixel_write_t       due;
	int                 errs = 0;

	task top_offset_store(input logic [7:0] b);
		top_ofs = b;
		phase = AWAIT_LEN;
	endtask

	// advance the parser by one column byte and queue what it writes
	task parse_column_byte(input logic [7:0] b);
		int row_start;
		int row_span;
		case (phase)
			AWAIT_TOP: begin
				if (b == END_MARK) begin
					expected_writes.push_back('{fin: 1'b1, row: 15'd0, pix: 8'd0});
				end else begin
					top_offset_store(b);
				end
			end
			AWAIT_LEN: begin
				// window is fixed here for the whole post
				row_start = int'(origin) + int'(top_ofs);
				row_span = int'(b);
				if (row_start < 0) begin
					row_span += row_start;
					row_start = 0;
				end
				if (row_start + row_span > int'(height))
					row_span = int'(height) - row_start;
				first_row = row_start[15:0];
				row_count = (row_span > 0) ? row_span[15:0] : 16'd0;
				bytes_rem = b;
				data_pos = 8'd0;
				phase = SKIP_PAD_HEAD;
			end
			SKIP_PAD_HEAD: begin
				phase = (bytes_rem == 8'd0) ? SKIP_PAD_TAIL : TAKE_DATA;
			end
			TAKE_DATA: begin
				if ({8'd0, data_pos} < row_count)
					expected_writes.push_back('{fin: 1'b0,
						row: 15'(first_row + {8'd0, data_pos}), pix: b});
				data_pos = data_pos + 8'd1;
				bytes_rem = bytes_rem - 8'd1;
				if (bytes_rem == 8'd0)
					phase = SKIP_PAD_TAIL;
			end
			default: begin
				phase = AWAIT_TOP;
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase = AWAIT_TOP;
			origin = 16'sd0;
			height = 15'd128;
			top_ofs = 8'd0;
			bytes_rem = 8'd0;
			data_pos = 8'd0;
			first_row = 16'd0;
			row_count = 16'd0;
			expected_writes.delete();
			pending <= 0;
			fail_count <= errs;
		end else begin
			// result transaction against the oldest expectation
			if (m_tvalid && m_tready) begin
				seen = '{fin: m_tuser, row: m_tdata[14:0], pix: m_tdata[22:15]};
				if (expected_writes.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("unexpected result: end %0b pos %0d byte %02h",
							seen.fin, seen.row, seen.pix);
				end else begin
					due = expected_writes.pop_front();
					if (seen.fin !== due.fin || seen.row !== due.row ||
						seen.pix !== due.pix) begin
						errs++;
						if (errs <= 10)
							$display("mismatch: expected end %0b pos %0d byte %02h,",
								due.fin, due.row, due.pix,
								" got end %0b pos %0d byte %02h",
								seen.fin, seen.row, seen.pix);
					end
				end
			end
			// register write transaction
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_ORIGIN_Y:     origin = cfg_data;
					CFG_CACHE_HEIGHT: height = cfg_data[14:0];
					default:          ;
				endcase
			end
			// column byte transaction
			if (s_tvalid && s_tready)
				parse_column_byte(s_tdata);
			fail_count <= errs;
			pending <= expected_writes.size();
		end
	end

endmodule

// ===== bench/column_post_clip_writer_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// column post clip writer testbench
// Feeds sparse column byte streams through the writer under several clip
// windows, with directed posts for the edge cases followed by random columns,
// random gaps on the byte stream and random stalls on the result stream.
// ----------------------------------------------------------------------------

module column_post_clip_writer_unit_tb;
	import cpcw_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;    // [7:0] column_byte
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;    // [14:0] write_pos, [22:15] write_byte, [23] zero
	logic        m_tuser;    // [0] column_end
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [15:0] cfg_data;

	int fail_count;
	int pending;
	int bytes_sent = 0;
	int stall_left = 0;
	bit idle_on = 1'b1;

	column_post_clip_writer_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	column_post_clip_writer_unit_checker write_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// receiver with bursts of stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(1, 3) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// one column byte transaction, maybe after a short gap
	task automatic push_byte(input logic [7:0] b);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
	endtask

	// stop the byte stream and wait until every result has come out
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// register write transaction; hold keeps valid up for a following write
	task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val, input bit hold);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (!hold)
			cfg_valid <= 1'b0;
	endtask

	// well formed post with random pads and data
	task automatic send_post(input logic [7:0] top, input int len);
		push_byte(top);
		push_byte(8'(len));
		push_byte(8'($urandom_range(0, 255)));
		for (int i = 0; i < len; i++)
			push_byte(8'($urandom_range(0, 255)));
		push_byte(8'($urandom_range(0, 255)));
	endtask

	// a few posts, now and then some stray bytes, then the terminator
	task automatic send_column();
		int posts;
		int len;
		logic [7:0] top;
		posts = $urandom_range(0, 3);
		repeat (posts) begin
			top = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 254))
				: 8'($urandom_range(0, 40));
			len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255)
				: $urandom_range(0, 12);
			send_post(top, len);
		end
		if ($urandom_range(0, 14) == 0)
			repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
		push_byte(END_MARK);
	endtask

	// one clip window setting and random columns until the quota is sent
	task automatic run_phase(input logic [15:0] org, input logic [14:0] ht,
		input int quota, input bit quiet);
		int stop;
		settle();
		idle_on = !quiet;
		write_reg(CFG_ORIGIN_Y, org, 1'b1);
		write_reg(CFG_CACHE_HEIGHT, {1'($urandom_range(0, 1)), ht}, 1'b0);
		stop = bytes_sent + quota;
		while (bytes_sent < stop)
			send_column();
	endtask

	// timeout
	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	// stimulus and verdict
	initial begin
		arst_n = 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= 8'd0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_ORIGIN_Y;
		cfg_data <= 16'd0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// post at row 0 with extreme data bytes, then terminator
		push_byte(8'd0);
		push_byte(8'd2);
		push_byte(8'h00);
		push_byte(8'h00);
		push_byte(8'hff);
		push_byte(8'hff);
		push_byte(END_MARK);
		// empty post at the highest top offset, then terminator
		push_byte(8'd254);
		push_byte(8'd0);
		push_byte(8'h5a);
		push_byte(8'ha5);
		push_byte(END_MARK);

		// negative start: copy begins at row 0 from the first data byte
		settle();
		write_reg(CFG_ORIGIN_Y, 16'hfffd, 1'b0);
		send_post(8'd1, 4);

		// origin change after the length byte leaves the current post unaffected
		push_byte(8'd5);
		push_byte(8'd3);
		settle();
		write_reg(CFG_ORIGIN_Y, 16'd10, 1'b0);
		push_byte(8'h11);
		push_byte(8'h80);
		push_byte(8'h7f);
		push_byte(8'h01);
		push_byte(8'h22);
		push_byte(END_MARK);

		// random columns across clip windows, extremes included
		run_phase(16'd0, 15'd128, 100, 1'b0);
		run_phase(-16'sd100, 15'd300, 110, 1'b0);
		run_phase(16'h8000, 15'd32767, 60, 1'b0);
		run_phase(16'h7fff, 15'd32767, 60, 1'b0);
		run_phase(16'd32600, 15'd32767, 100, 1'b0);
		run_phase(16'd0, 15'd0, 60, 1'b0);
		run_phase(-16'sd5, 15'd20, 100, 1'b1);
		run_phase(16'($urandom_range(0, 400) - 200), 15'($urandom_range(1, 400)),
			100, 1'b0);
		run_phase(-16'sd20, 15'd64, 100, 1'b1);

		settle();
		if (fail_count == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
